// File: rtl/crs_pkg.sv
`default_nettype none
package crs_pkg;

    // word format of every input and solution field (signed Q16.16)
    localparam int W     = 32;
    localparam int FRAC  = 16;
    // cross product component, one 2x2 minor of two columns
    localparam int XW    = 2 * W + 1;
    // partial product of a minor half by a column entry
    localparam int PW    = 2 * W + 1;
    // triple product, exact
    localparam int VW    = 100;
    // quotient bits produced by the divider (bit 32 down to bit 0)
    localparam int QW    = W + 1;
    localparam int NSTEP = QW;
    // divider remainder width: magnitude of the shifted numerator and of den << (NSTEP-1)
    localparam int RW    = VW + NSTEP - 1;

    localparam logic [QW-1:0] Q_HALF  = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  SOL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SOL_MIN = {1'b1, {(W-1){1'b0}}};

    typedef logic [2:0][W-1:0] t_vec3;

    // determinant and the three column-replaced triple products
    typedef struct packed {
        logic [VW-1:0]        det;
        logic [2:0][VW-1:0]   num;
    } t_trip;

    // raw quotient magnitudes with sign and range status
    typedef struct packed {
        logic [2:0][QW-1:0]   q;
        logic [2:0]           neg;
        logic [2:0]           big;
        logic                 sing;
    } t_quo;

endpackage
`default_nettype wire

// File: rtl/crs_det.sv
`default_nettype none
module crs_det (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  crs_pkg::t_vec3  i_c1,
    input  crs_pkg::t_vec3  i_c2,
    input  crs_pkg::t_vec3  i_c3,
    input  crs_pkg::t_vec3  i_rhs,
    output logic            o_valid,
    input  logic            i_ready,
    output crs_pkg::t_trip  o_trip
);
    import crs_pkg::*;

    localparam int NS = 5;
    localparam int NX1[3] = '{1, 2, 0};
    localparam int NX2[3] = '{2, 0, 1};
    // cross product used by each dot: det and x1 use c2 x c3, x2 uses b x c3, x3 uses c2 x b
    localparam int SEL_X[4] = '{0, 0, 1, 2};

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    // stage ready: a stage loads when empty or when its beat moves on
    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage A: the two products of every 2x2 minor
    t_vec3 u_sel [3];
    t_vec3 v_sel [3];
    logic signed [2*W-1:0] r_pl [3][3];
    logic signed [2*W-1:0] r_pr [3][3];
    t_vec3 r_a_c1, r_a_b;

    always_comb begin
        u_sel[0] = i_c2;  v_sel[0] = i_c3;
        u_sel[1] = i_rhs; v_sel[1] = i_c3;
        u_sel[2] = i_c2;  v_sel[2] = i_rhs;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int m = 0; m < 3; m++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pl[m][i] <= $signed(u_sel[m][NX1[i]]) * $signed(v_sel[m][NX2[i]]);
                    r_pr[m][i] <= $signed(u_sel[m][NX2[i]]) * $signed(v_sel[m][NX1[i]]);
                end
            end
            r_a_c1 <= i_c1;
            r_a_b  <= i_rhs;
        end
    end

    // stage B: minors
    logic signed [XW-1:0] r_x [3][3];
    t_vec3 r_b_c1, r_b_b;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int m = 0; m < 3; m++) begin
                for (int i = 0; i < 3; i++) begin
                    r_x[m][i] <= XW'(r_pl[m][i]) - XW'(r_pr[m][i]);
                end
            end
            r_b_c1 <= r_a_c1;
            r_b_b  <= r_a_b;
        end
    end

    // stage C: split each minor into halves and multiply by the column entry
    logic signed [PW-1:0] r_ph [4][3];
    logic signed [PW-1:0] r_plo [4][3];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_ph[j][i] <= $signed(r_x[SEL_X[j]][i][XW-1:W])
                                * $signed((j == 1) ? r_b_b[i] : r_b_c1[i]);
                    r_plo[j][i] <= $signed({1'b0, r_x[SEL_X[j]][i][W-1:0]})
                                 * $signed((j == 1) ? r_b_b[i] : r_b_c1[i]);
                end
            end
        end
    end

    // stage D: recombine halves into full terms
    logic signed [VW-1:0] r_t [4][3];

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_t[j][i] <= (VW'(r_ph[j][i]) <<< W) + VW'(r_plo[j][i]);
                end
            end
        end
    end

    // stage E: sum terms into triple products
    logic signed [VW-1:0] r_s [4];

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int j = 0; j < 4; j++) begin
                r_s[j] <= r_t[j][0] + r_t[j][1] + r_t[j][2];
            end
        end
    end

    always_comb begin
        o_trip.det = r_s[0];
        for (int i = 0; i < 3; i++) begin
            o_trip.num[i] = r_s[i+1];
        end
    end

endmodule
`default_nettype wire

// File: rtl/crs_div.sv
`default_nettype none
module crs_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  crs_pkg::t_trip  i_trip,
    output logic            o_valid,
    input  logic            i_ready,
    output crs_pkg::t_quo   o_quo
);
    import crs_pkg::*;

    // prep stage, then one restoring step per quotient bit
    localparam int NS = NSTEP + 1;

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    logic [RW-1:0] r_rem [NS][3];
    logic [QW-1:0] r_q   [NS][3];
    logic [VW-1:0] r_den [NS];
    logic [2:0]    r_neg [NS];
    logic [2:0]    r_big [NS];
    logic          r_sing [NS];

    // prep: magnitudes, scale numerator, flag quotients of 2^33 and above
    logic [VW-1:0] det_mag;
    logic          det_neg;
    logic [VW-1:0] num_mag [3];
    logic [RW-1:0] n_rem [3];
    logic [2:0]    n_neg;
    logic [2:0]    n_big;

    always_comb begin
        det_neg = i_trip.det[VW-1];
        det_mag = det_neg ? (VW'(0) - i_trip.det) : i_trip.det;
        for (int i = 0; i < 3; i++) begin
            num_mag[i] = i_trip.num[i][VW-1] ? (VW'(0) - i_trip.num[i]) : i_trip.num[i];
            n_rem[i]   = RW'({num_mag[i], {FRAC{1'b0}}});
            n_neg[i]   = i_trip.num[i][VW-1] ^ det_neg;
            n_big[i]   = (RW+1)'(n_rem[i]) >= {det_mag, {NSTEP{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= n_rem[i];
                r_q[0][i]   <= '0;
            end
            r_den[0]  <= det_mag;
            r_neg[0]  <= n_neg;
            r_big[0]  <= n_big;
            r_sing[0] <= (i_trip.det == '0);
        end
    end

    // restoring steps, most significant quotient bit first
    for (genvar s = 1; s < NS; s++) begin : g_step
        localparam int K = NSTEP - s;
        logic [RW-1:0] dk;
        logic [2:0]    ge;

        always_comb begin
            dk = RW'(r_den[s-1]) << K;
            for (int i = 0; i < 3; i++) begin
                ge[i] = r_rem[s-1][i] >= dk;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[s]) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[s][i] <= ge[i] ? (r_rem[s-1][i] - dk) : r_rem[s-1][i];
                    r_q[s][i]   <= r_q[s-1][i] | (QW'(ge[i]) << K);
                end
                r_den[s]  <= r_den[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_big[s]  <= r_big[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_quo.q[i] = r_q[NS-1][i];
        end
        o_quo.neg  = r_neg[NS-1];
        o_quo.big  = r_big[NS-1];
        o_quo.sing = r_sing[NS-1];
    end

endmodule
`default_nettype wire

// File: rtl/cramer_solve_3x3_core.sv
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// input    | i_valid / o_ready    | i_a11..i_a33 (column order), i_rhs_1..i_rhs_3
// output   | o_valid / i_ready    | o_sol_1..o_sol_3, o_singular, o_overflowed
//
// One system enters per cycle while o_ready is high. The path runs through the
// triple-product stages, one divider prep stage, 33 restoring divider steps (one
// quotient bit each) and the output register.
// Reset clears only the stage valid bits; no clearing pass.
// A stall holds each full stage; empty stages still fill, so bubbles collapse.
module cramer_solve_3x3_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_a11,
    input  logic signed [31:0]   i_a21,
    input  logic signed [31:0]   i_a31,
    input  logic signed [31:0]   i_a12,
    input  logic signed [31:0]   i_a22,
    input  logic signed [31:0]   i_a32,
    input  logic signed [31:0]   i_a13,
    input  logic signed [31:0]   i_a23,
    input  logic signed [31:0]   i_a33,
    input  logic signed [31:0]   i_rhs_1,
    input  logic signed [31:0]   i_rhs_2,
    input  logic signed [31:0]   i_rhs_3,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_sol_1,
    output logic signed [31:0]   o_sol_2,
    output logic signed [31:0]   o_sol_3,
    output logic                 o_singular,
    output logic                 o_overflowed
);
    import crs_pkg::*;

    t_vec3 c1, c2, c3, rhs;
    t_trip trip;
    t_quo  quo;
    logic  det_vld, det_rdy, div_vld, out_rdy;

    assign c1  = {i_a31, i_a21, i_a11};
    assign c2  = {i_a32, i_a22, i_a12};
    assign c3  = {i_a33, i_a23, i_a13};
    assign rhs = {i_rhs_3, i_rhs_2, i_rhs_1};

    crs_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_c1    (c1),
        .i_c2    (c2),
        .i_c3    (c3),
        .i_rhs   (rhs),
        .o_valid (det_vld),
        .i_ready (det_rdy),
        .o_trip  (trip)
    );

    crs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (det_vld),
        .o_ready (det_rdy),
        .i_trip  (trip),
        .o_valid (div_vld),
        .i_ready (out_rdy),
        .o_quo   (quo)
    );

    // zero singular results, saturate quotients and apply sign
    logic [W-1:0] n_sol [3];
    logic [2:0]   lane_ovf;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lane_ovf[i] = 1'b0;
            if (quo.sing) begin
                n_sol[i] = '0;
            end else if (quo.big[i]) begin
                n_sol[i]    = quo.neg[i] ? SOL_MIN : SOL_MAX;
                lane_ovf[i] = 1'b1;
            end else if (quo.neg[i]) begin
                if (quo.q[i] > Q_HALF) begin
                    n_sol[i]    = SOL_MIN;
                    lane_ovf[i] = 1'b1;
                end else begin
                    n_sol[i] = W'(QW'(~quo.q[i]) + QW'(1));
                end
            end else begin
                if (quo.q[i] > (Q_HALF - QW'(1))) begin
                    n_sol[i]    = SOL_MAX;
                    lane_ovf[i] = 1'b1;
                end else begin
                    n_sol[i] = W'(quo.q[i]);
                end
            end
        end
    end

    // output register
    logic         r_vld;
    logic [W-1:0] r_sol [3];
    logic         r_sing, r_ovf;

    assign out_rdy = ~r_vld | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (out_rdy) begin
            r_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            for (int i = 0; i < 3; i++) begin
                r_sol[i] <= n_sol[i];
            end
            r_sing <= quo.sing;
            r_ovf  <= |lane_ovf;
        end
    end

    assign o_valid      = r_vld;
    assign o_sol_1      = r_sol[0];
    assign o_sol_2      = r_sol[1];
    assign o_sol_3      = r_sol[2];
    assign o_singular   = r_sing;
    assign o_overflowed = r_ovf;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_sol_1 == '0 && o_sol_2 == '0 && o_sol_3 == '0
                                  && !o_overflowed)
        else $error("singular result not forced to zero");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |->
            o_sol_1 == SOL_MAX || o_sol_1 == SOL_MIN || o_sol_2 == SOL_MAX
            || o_sol_2 == SOL_MIN || o_sol_3 == SOL_MAX || o_sol_3 == SOL_MIN)
        else $error("overflow flagged without a clamped component");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
